>>> rtl/mmh_pkg.sv
// Shared constants and a helper function of the min-max heap block.
package mmh_pkg;

    localparam int OP_W     = 2;
    localparam int KEY_W    = 32;
    localparam int STATUS_W = 2;
    localparam int COUNT_W  = 10;

    localparam logic [OP_W-1:0] OP_INSERT      = 2'd0;
    localparam logic [OP_W-1:0] OP_REMOVE_MIN  = 2'd1;
    localparam logic [OP_W-1:0] OP_REMOVE_MAX  = 2'd2;
    localparam logic [OP_W-1:0] OP_REPLACE_MAX = 2'd3;

    localparam logic [STATUS_W-1:0] STAT_DONE  = 2'd0;
    localparam logic [STATUS_W-1:0] STAT_EMPTY = 2'd1;
    localparam logic [STATUS_W-1:0] STAT_FULL  = 2'd2;

    // True when the tree level of a one-based position is odd (maximum order).
    function automatic logic level_odd(input logic [31:0] pos);
        logic odd;
        odd = 1'b0;
        for (int i = 1; i < 32; i++)
        begin
            if (pos[i])
            begin
                odd = i[0];
            end
        end
        return odd;
    endfunction

endpackage

>>> rtl/mmh_req_if.sv
// Request channel: operation code and key.
interface mmh_req_if;
    logic                       valid;
    logic                       ready;
    logic [mmh_pkg::OP_W-1:0]   op;
    logic [mmh_pkg::KEY_W-1:0]  key_in;

    modport source (output valid, op, key_in, input ready);
    modport sink   (input valid, op, key_in, output ready);
endinterface

>>> rtl/mmh_rsp_if.sv
// Response channel: removed key, status, extremes and element count.
interface mmh_rsp_if;
    logic                          valid;
    logic                          ready;
    logic [mmh_pkg::KEY_W-1:0]     removed_key;
    logic [mmh_pkg::STATUS_W-1:0]  status;
    logic [mmh_pkg::KEY_W-1:0]     min_key;
    logic [mmh_pkg::KEY_W-1:0]     max_key;
    logic [mmh_pkg::COUNT_W-1:0]   count_out;

    modport source (output valid, removed_key, status, min_key, max_key, count_out,
                    input ready);
    modport sink   (input valid, removed_key, status, min_key, max_key, count_out,
                    output ready);
endinterface

>>> rtl/mmh_mem.sv
// Heap key store: one write port and one registered read port.
module mmh_mem #(
    parameter int DEPTH = 1024,
    parameter int AW    = 10,
    parameter int KW    = 32
) (
    input  logic          clk,
    input  logic          we,
    input  logic [AW-1:0] wr_addr,
    input  logic [KW-1:0] wr_data,
    input  logic          rd_en,
    input  logic [AW-1:0] rd_addr,
    output logic [KW-1:0] rd_data
);

    logic [KW-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[wr_addr] <= wr_data;
        end
    end

    always_ff @(posedge clk)
    begin
        if (rd_en)
        begin
            rd_data <= mem[rd_addr];
        end
    end

endmodule

>>> rtl/mmh_cmp.sv
// Shared key comparator: tells whether a key ranks ahead of another on a level.
module mmh_cmp #(
    parameter int KW = 32
) (
    input  logic [KW-1:0] a,
    input  logic [KW-1:0] b,
    input  logic          max_order,
    output logic          ahead
);

    logic gt;
    logic lt;

    assign gt    = a > b;
    assign lt    = a < b;
    assign ahead = max_order ? gt : lt;

endmodule

>>> rtl/min_max_double_ended_heap.sv
// Top level of the min-max heap: sequencer around the key store and comparator.
//
//  channel | dir | handshake     | word
//  --------+-----+---------------+---------------------------------------------
//  req     | in  | valid / ready | op, key_in
//  rsp     | out | valid / ready | removed_key, status, min_key, max_key, count_out
//
// One request at a time; the store has a single read port, so keys are read one after
// another. An insert compares with its parent, then climbs one grandparent step at a
// time. A removal reads the top three entries and the last entry, then descends one
// grandchild level at a time, with up to six descendant reads per level, and takes one
// more write state when a child moves. A replace removes the maximum, then inserts the
// new key.
// Reset clears the count and the control state; the key store keeps its contents.
// A finished word waits in the output register while the next request is taken.
module min_max_double_ended_heap #(
    parameter int CAPACITY = 1023,
    parameter int KEY_BITS = 32
) (
    input  logic         clk,
    input  logic         rst_n,
    mmh_req_if.sink      req,
    mmh_rsp_if.source    rsp
);

    localparam int CW = $clog2(CAPACITY + 1);
    localparam int PW = CW + 2;
    localparam int KW = KEY_BITS;

    typedef enum logic [15:0] {
        S_IDLE   = 16'b0000_0000_0000_0001,
        S_START  = 16'b0000_0000_0000_0010,
        S_TOPS   = 16'b0000_0000_0000_0100,
        S_PICK   = 16'b0000_0000_0000_1000,
        S_LAST   = 16'b0000_0000_0001_0000,
        S_SDINIT = 16'b0000_0000_0010_0000,
        S_SCAN   = 16'b0000_0000_0100_0000,
        S_DEC    = 16'b0000_0000_1000_0000,
        S_GPAR   = 16'b0000_0001_0000_0000,
        S_CWR    = 16'b0000_0010_0000_0000,
        S_INS    = 16'b0000_0100_0000_0000,
        S_UP1    = 16'b0000_1000_0000_0000,
        S_CLIMB  = 16'b0001_0000_0000_0000,
        S_CLCMP  = 16'b0010_0000_0000_0000,
        S_FIN    = 16'b0100_0000_0000_0000,
        S_OUT    = 16'b1000_0000_0000_0000
    } state_t;

    state_t                          state_reg, state_next;
    logic [mmh_pkg::OP_W-1:0]        op_reg, op_next;
    logic [KW-1:0]                   keyin_reg, keyin_next;
    logic [KW-1:0]                   x_reg, x_next;
    logic [CW-1:0]                   cnt_reg, cnt_next;
    logic [PW-1:0]                   h_reg, h_next;
    logic                            ord_reg, ord_next;
    logic                            final_reg, final_next;
    logic [1:0]                      tcnt_reg, tcnt_next;
    logic [KW-1:0]                   v1_reg, v1_next;
    logic [KW-1:0]                   v2_reg, v2_next;
    logic [KW-1:0]                   v3_reg, v3_next;
    logic [PW-1:0]                   sidx_reg, sidx_next;
    logic [PW-1:0]                   raddr_reg, raddr_next;
    logic                            inflight_reg, inflight_next;
    logic                            issue_reg, issue_next;
    logic [KW-1:0]                   best_reg, best_next;
    logic [PW-1:0]                   bidx_reg, bidx_next;
    logic [KW-1:0]                   c0_reg, c0_next;
    logic [KW-1:0]                   c1_reg, c1_next;
    logic [KW-1:0]                   removed_reg, removed_next;
    logic [mmh_pkg::STATUS_W-1:0]    status_reg, status_next;
    logic [KW-1:0]                   min_reg, min_next;
    logic [KW-1:0]                   max_reg, max_next;

    logic                            ov_reg, ov_next;
    logic [mmh_pkg::KEY_W-1:0]       orem_reg, orem_next;
    logic [mmh_pkg::STATUS_W-1:0]    ostat_reg, ostat_next;
    logic [mmh_pkg::KEY_W-1:0]       omin_reg, omin_next;
    logic [mmh_pkg::KEY_W-1:0]       omax_reg, omax_next;
    logic [mmh_pkg::COUNT_W-1:0]     ocnt_reg, ocnt_next;

    logic                            rd_en;
    logic [CW-1:0]                   rd_addr;
    logic [KW-1:0]                   rd_data;
    logic                            we;
    logic [CW-1:0]                   wr_addr;
    logic [KW-1:0]                   wr_data;

    logic [KW-1:0]                   cmp_a;
    logic [KW-1:0]                   cmp_b;
    logic                            cmp_max;
    logic                            ahead;

    logic [PW-1:0]                   n_pos;
    logic [PW-1:0]                   c_pos;
    logic [PW-1:0]                   g_pos;
    logic [CW-1:0]                   cnt_inc;
    logic [PW-1:0]                   ins_pos;
    logic [63:0]                     key_wide;
    logic [63:0]                     rem_wide;
    logic [63:0]                     min_wide;
    logic [63:0]                     max_wide;
    logic [31:0]                     cnt_wide;
    logic [1:0]                      mp;
    logic [KW-1:0]                   mv;
    logic                            mx_up;
    logic                            ord_h;
    state_t                          after_rm;

    assign n_pos    = PW'(cnt_reg);
    assign c_pos    = {h_reg[PW-2:0], 1'b0};
    assign g_pos    = {h_reg[PW-3:0], 2'b00};
    assign cnt_inc  = cnt_reg + 1'b1;
    assign ins_pos  = PW'(cnt_inc);
    assign key_wide = 64'(req.key_in);
    assign mx_up    = mmh_pkg::level_odd(32'(h_reg));
    assign ord_h    = mmh_pkg::level_odd(32'(h_reg));
    assign after_rm = (op_reg == mmh_pkg::OP_REPLACE_MAX) ? S_INS : S_FIN;

    // Position of the maximum among the top three entries.
    always_comb
    begin
        if (cnt_reg == CW'(1))
        begin
            mp = 2'd1;
            mv = v1_reg;
        end
        else if (cnt_reg == CW'(2) || ahead)
        begin
            mp = 2'd2;
            mv = v2_reg;
        end
        else
        begin
            mp = 2'd3;
            mv = v3_reg;
        end
    end

    mmh_mem #(
        .DEPTH (CAPACITY + 1),
        .AW    (CW),
        .KW    (KW)
    ) u_mem (
        .clk     (clk),
        .we      (we),
        .wr_addr (wr_addr),
        .wr_data (wr_data),
        .rd_en   (rd_en),
        .rd_addr (rd_addr),
        .rd_data (rd_data)
    );

    mmh_cmp #(
        .KW (KW)
    ) u_cmp (
        .a         (cmp_a),
        .b         (cmp_b),
        .max_order (cmp_max),
        .ahead     (ahead)
    );

    // Comparator operands follow the sequencer state.
    always_comb
    begin
        cmp_a   = rd_data;
        cmp_b   = best_reg;
        cmp_max = ord_reg;
        unique case (state_reg)
            S_PICK:
            begin
                cmp_a   = v2_reg;
                cmp_b   = v3_reg;
                cmp_max = 1'b1;
            end
            S_DEC:
            begin
                cmp_a = best_reg;
                cmp_b = x_reg;
            end
            S_GPAR:
            begin
                cmp_a = ((bidx_reg >> 1) == c_pos) ? c0_reg : c1_reg;
                cmp_b = x_reg;
            end
            S_UP1:
            begin
                cmp_a   = rd_data;
                cmp_b   = x_reg;
                cmp_max = mx_up;
            end
            S_CLCMP:
            begin
                cmp_a = x_reg;
                cmp_b = rd_data;
            end
            default:
            begin
                cmp_a   = rd_data;
                cmp_b   = best_reg;
                cmp_max = ord_reg;
            end
        endcase
    end

    always_comb
    begin
        state_next    = state_reg;
        op_next       = op_reg;
        keyin_next    = keyin_reg;
        x_next        = x_reg;
        cnt_next      = cnt_reg;
        h_next        = h_reg;
        ord_next      = ord_reg;
        final_next    = final_reg;
        tcnt_next     = tcnt_reg;
        v1_next       = v1_reg;
        v2_next       = v2_reg;
        v3_next       = v3_reg;
        sidx_next     = sidx_reg;
        raddr_next    = raddr_reg;
        inflight_next = inflight_reg;
        issue_next    = issue_reg;
        best_next     = best_reg;
        bidx_next     = bidx_reg;
        c0_next       = c0_reg;
        c1_next       = c1_reg;
        removed_next  = removed_reg;
        status_next   = status_reg;
        min_next      = min_reg;
        max_next      = max_reg;
        ov_next       = ov_reg;
        orem_next     = orem_reg;
        ostat_next    = ostat_reg;
        omin_next     = omin_reg;
        omax_next     = omax_reg;
        ocnt_next     = ocnt_reg;
        rd_en         = 1'b0;
        rd_addr       = '0;
        we            = 1'b0;
        wr_addr       = '0;
        wr_data       = x_reg;
        rem_wide      = 64'(removed_reg);
        min_wide      = 64'(min_reg);
        max_wide      = 64'(max_reg);
        cnt_wide      = 32'(cnt_reg);

        if (rsp.valid && rsp.ready)
        begin
            ov_next = 1'b0;
        end

        unique case (state_reg)
            S_IDLE:
            begin
                if (req.valid)
                begin
                    op_next      = req.op;
                    keyin_next   = key_wide[KW-1:0];
                    removed_next = '0;
                    status_next  = mmh_pkg::STAT_DONE;
                    state_next   = S_START;
                end
            end
            S_START:
            begin
                tcnt_next  = 2'd0;
                final_next = 1'b0;
                if (op_reg == mmh_pkg::OP_INSERT)
                begin
                    if (cnt_reg >= CW'(CAPACITY))
                    begin
                        status_next = mmh_pkg::STAT_FULL;
                        state_next  = S_FIN;
                    end
                    else
                    begin
                        state_next = S_INS;
                    end
                end
                else if (cnt_reg == '0)
                begin
                    status_next = mmh_pkg::STAT_EMPTY;
                    state_next  = S_FIN;
                end
                else
                begin
                    state_next = S_TOPS;
                end
            end
            S_TOPS:
            begin
                // Entries one to three are read back to back; read data arrives in the cycle after its address.
                if (tcnt_reg != 2'd3)
                begin
                    rd_en   = 1'b1;
                    rd_addr = CW'(tcnt_reg) + 1'b1;
                end
                case (tcnt_reg)
                    2'd1:    v1_next = rd_data;
                    2'd2:    v2_next = rd_data;
                    2'd3:    v3_next = rd_data;
                    default: v1_next = v1_reg;
                endcase
                tcnt_next = tcnt_reg + 1'b1;
                if (tcnt_reg == 2'd3)
                begin
                    state_next = S_PICK;
                end
            end
            S_PICK:
            begin
                if (final_reg)
                begin
                    min_next   = v1_reg;
                    max_next   = mv;
                    state_next = S_OUT;
                end
                else
                begin
                    if (op_reg == mmh_pkg::OP_REMOVE_MIN)
                    begin
                        h_next       = PW'(1);
                        removed_next = v1_reg;
                    end
                    else
                    begin
                        h_next       = PW'(mp);
                        removed_next = mv;
                    end
                    rd_en      = 1'b1;
                    rd_addr    = cnt_reg;
                    state_next = S_LAST;
                end
            end
            S_LAST:
            begin
                x_next     = rd_data;
                cnt_next   = cnt_reg - 1'b1;
                ord_next   = ord_h;
                state_next = S_SDINIT;
            end
            S_SDINIT:
            begin
                sidx_next     = c_pos;
                issue_next    = 1'b1;
                inflight_next = 1'b0;
                bidx_next     = '0;
                state_next    = S_SCAN;
            end
            S_SCAN:
            begin
                // Children and grandchildren stream through the comparator.
                if (inflight_reg)
                begin
                    if (bidx_reg == '0 || ahead)
                    begin
                        best_next = rd_data;
                        bidx_next = raddr_reg;
                    end
                    if (raddr_reg == c_pos)
                    begin
                        c0_next = rd_data;
                    end
                    if (raddr_reg == c_pos + 1'b1)
                    begin
                        c1_next = rd_data;
                    end
                end
                if (issue_reg && sidx_reg <= n_pos)
                begin
                    rd_en         = 1'b1;
                    rd_addr       = sidx_reg[CW-1:0];
                    inflight_next = 1'b1;
                    raddr_next    = sidx_reg;
                    sidx_next     = (sidx_reg == c_pos + 1'b1) ? g_pos : sidx_reg + 1'b1;
                    if (sidx_reg == g_pos + PW'(3))
                    begin
                        issue_next = 1'b0;
                    end
                end
                else
                begin
                    issue_next    = 1'b0;
                    inflight_next = 1'b0;
                end
                if (!issue_reg && !inflight_reg)
                begin
                    state_next = S_DEC;
                end
            end
            S_DEC:
            begin
                we      = 1'b1;
                wr_addr = h_reg[CW-1:0];
                if (bidx_reg == '0 || !ahead)
                begin
                    wr_data    = x_reg;
                    state_next = after_rm;
                end
                else
                begin
                    wr_data    = best_reg;
                    state_next = (bidx_reg >= g_pos) ? S_GPAR : S_CWR;
                end
            end
            S_GPAR:
            begin
                if (ahead)
                begin
                    we      = 1'b1;
                    wr_addr = bidx_reg[CW:1];
                    wr_data = x_reg;
                    x_next  = cmp_a;
                end
                h_next     = bidx_reg;
                state_next = S_SDINIT;
            end
            S_CWR:
            begin
                we         = 1'b1;
                wr_addr    = bidx_reg[CW-1:0];
                wr_data    = x_reg;
                state_next = after_rm;
            end
            S_INS:
            begin
                x_next   = keyin_reg;
                cnt_next = cnt_inc;
                h_next   = ins_pos;
                if (cnt_inc == CW'(1))
                begin
                    we         = 1'b1;
                    wr_addr    = CW'(1);
                    wr_data    = keyin_reg;
                    state_next = S_FIN;
                end
                else
                begin
                    rd_en      = 1'b1;
                    rd_addr    = ins_pos[CW:1];
                    state_next = S_UP1;
                end
            end
            S_UP1:
            begin
                if (ahead)
                begin
                    we       = 1'b1;
                    wr_addr  = h_reg[CW-1:0];
                    wr_data  = rd_data;
                    h_next   = h_reg >> 1;
                    ord_next = !mx_up;
                end
                else
                begin
                    ord_next = mx_up;
                end
                state_next = S_CLIMB;
            end
            S_CLIMB:
            begin
                if ((h_reg >> 2) != '0)
                begin
                    rd_en      = 1'b1;
                    rd_addr    = h_reg[CW+1:2];
                    state_next = S_CLCMP;
                end
                else
                begin
                    we         = 1'b1;
                    wr_addr    = h_reg[CW-1:0];
                    wr_data    = x_reg;
                    state_next = S_FIN;
                end
            end
            S_CLCMP:
            begin
                we      = 1'b1;
                wr_addr = h_reg[CW-1:0];
                if (ahead)
                begin
                    wr_data    = rd_data;
                    h_next     = h_reg >> 2;
                    state_next = S_CLIMB;
                end
                else
                begin
                    wr_data    = x_reg;
                    state_next = S_FIN;
                end
            end
            S_FIN:
            begin
                tcnt_next  = 2'd0;
                final_next = 1'b1;
                if (cnt_reg == '0)
                begin
                    min_next   = '0;
                    max_next   = '0;
                    state_next = S_OUT;
                end
                else
                begin
                    state_next = S_TOPS;
                end
            end
            S_OUT:
            begin
                if (!ov_reg || rsp.ready)
                begin
                    ov_next    = 1'b1;
                    orem_next  = rem_wide[31:0];
                    ostat_next = status_reg;
                    omin_next  = min_wide[31:0];
                    omax_next  = max_wide[31:0];
                    ocnt_next  = cnt_wide[mmh_pkg::COUNT_W-1:0];
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg    <= S_IDLE;
            cnt_reg      <= '0;
            ov_reg       <= 1'b0;
            issue_reg    <= 1'b0;
            inflight_reg <= 1'b0;
        end
        else
        begin
            state_reg    <= state_next;
            cnt_reg      <= cnt_next;
            ov_reg       <= ov_next;
            issue_reg    <= issue_next;
            inflight_reg <= inflight_next;
        end
    end

    always_ff @(posedge clk)
    begin
        op_reg      <= op_next;
        keyin_reg   <= keyin_next;
        x_reg       <= x_next;
        h_reg       <= h_next;
        ord_reg     <= ord_next;
        final_reg   <= final_next;
        tcnt_reg    <= tcnt_next;
        v1_reg      <= v1_next;
        v2_reg      <= v2_next;
        v3_reg      <= v3_next;
        sidx_reg    <= sidx_next;
        raddr_reg   <= raddr_next;
        best_reg    <= best_next;
        bidx_reg    <= bidx_next;
        c0_reg      <= c0_next;
        c1_reg      <= c1_next;
        removed_reg <= removed_next;
        status_reg  <= status_next;
        min_reg     <= min_next;
        max_reg     <= max_next;
        orem_reg    <= orem_next;
        ostat_reg   <= ostat_next;
        omin_reg    <= omin_next;
        omax_reg    <= omax_next;
        ocnt_reg    <= ocnt_next;
    end

    assign req.ready       = (state_reg == S_IDLE);
    assign rsp.valid       = ov_reg;
    assign rsp.removed_key = orem_reg;
    assign rsp.status      = ostat_reg;
    assign rsp.min_key     = omin_reg;
    assign rsp.max_key     = omax_reg;
    assign rsp.count_out   = ocnt_reg;

endmodule

>>> rtl/mmh_chk.sv
// Port-level checker for the min-max heap, attached to the top level by bind.
module mmh_chk (
    input logic                          clk,
    input logic                          rst_n,
    input logic                          rsp_valid,
    input logic                          rsp_ready,
    input logic [mmh_pkg::KEY_W-1:0]     removed_key,
    input logic [mmh_pkg::STATUS_W-1:0]  status,
    input logic [mmh_pkg::KEY_W-1:0]     min_key,
    input logic [mmh_pkg::KEY_W-1:0]     max_key,
    input logic [mmh_pkg::COUNT_W-1:0]   count_out
);

    // A stalled word stays valid and keeps its keys and count.
    a_rsp_hold: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && !rsp_ready |=> rsp_valid && $stable(removed_key)
            && $stable(min_key) && $stable(max_key) && $stable(count_out))
        else $error("response word changed while stalled");

    // A rejected removal means an empty heap with nothing taken out.
    a_empty: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && status == mmh_pkg::STAT_EMPTY |-> removed_key == '0
            && count_out == '0 && min_key == '0 && max_key == '0)
        else $error("empty rejection reports keys");

    // A rejected insert takes nothing out.
    a_full: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && status == mmh_pkg::STAT_FULL |-> removed_key == '0
            && count_out != '0)
        else $error("full rejection reports a removed key");

    // The extremes are ordered whenever keys are held.
    a_order: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && count_out != '0 |-> min_key <= max_key)
        else $error("minimum above maximum");

endmodule

bind min_max_double_ended_heap mmh_chk u_chk (
    .clk         (clk),
    .rst_n       (rst_n),
    .rsp_valid   (rsp.valid),
    .rsp_ready   (rsp.ready),
    .removed_key (rsp.removed_key),
    .status      (rsp.status),
    .min_key     (rsp.min_key),
    .max_key     (rsp.max_key),
    .count_out   (rsp.count_out)
);
